@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/lpm_pkg.sv @@
`timescale 1ns / 1ps
package lpm_pkg;
    localparam int WIN_BITS = 14;
    localparam int PTR_BITS = 16;
    localparam int DEFAULT_W = 320;
    localparam int DEFAULT_H = 240;

    localparam logic [1:0] REG_WIN_W = 2'd0;
    localparam logic [1:0] REG_WIN_H = 2'd1;
    localparam logic [1:0] REG_IMG_W = 2'd2;
    localparam logic [1:0] REG_IMG_H = 2'd3;

    typedef struct packed {
        logic zero;
        logic clamp;
    } flags_t;

    typedef struct packed {
        logic [WIN_BITS-1:0] dst_x;
        logic [WIN_BITS-1:0] dst_y;
        logic [WIN_BITS-1:0] dst_w;
        logic [WIN_BITS-1:0] dst_h;
        logic                busy;
    } geom_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } setup_state_t;
endpackage

@@ rtl/letterbox_pointer_mapper_unit.sv @@
`timescale 1ns / 1ps
// Letterbox pointer mapper. Takes one pointer word per cycle while the output
// is not stalled and returns the matching image pixel through a row of divider
// cells that each resolve one quotient bit (image dimension 9 bits minimum).
// After reset and after every register write the bar geometry is recomputed
// by a bit-serial divider; s_tready stays low meanwhile.
`include "assert_macros.svh"
module letterbox_pointer_mapper_unit #(
    parameter int IMAGE_DIM_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] pointer_x, [31:16] pointer_y
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [D-1:0] image_x, [2D-1:D] image_y, zero fill to bytes
    output logic [((2*IMAGE_DIM_BITS+7)/8)*8-1:0] m_tdata
);
    localparam int D  = IMAGE_DIM_BITS;
    localparam int DW = (D > 9) ? D : 9;
    localparam int OW = ((2 * D + 7) / 8) * 8;
    localparam int WB = lpm_pkg::WIN_BITS;
    localparam int PW = 15 + DW;

    logic [WB-1:0] win_w_reg, win_h_reg;
    logic [D-1:0]  img_w_reg, img_h_reg;
    logic [DW-1:0] dim_w, dim_h;
    logic          cfg_wr;
    lpm_pkg::geom_t geom;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_w_reg <= WB'(640);
            win_h_reg <= WB'(480);
            img_w_reg <= '0;
            img_h_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                lpm_pkg::REG_WIN_W: win_w_reg <= pwdata[WB-1:0];
                lpm_pkg::REG_WIN_H: win_h_reg <= pwdata[WB-1:0];
                lpm_pkg::REG_IMG_W: img_w_reg <= pwdata[D-1:0];
                lpm_pkg::REG_IMG_H: img_h_reg <= pwdata[D-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            lpm_pkg::REG_WIN_W: prdata = 32'(win_w_reg);
            lpm_pkg::REG_WIN_H: prdata = 32'(win_h_reg);
            lpm_pkg::REG_IMG_W: prdata = 32'(img_w_reg);
            lpm_pkg::REG_IMG_H: prdata = 32'(img_h_reg);
            default:            prdata = '0;
        endcase
    end

    assign dim_w = (img_w_reg == '0) ? DW'(lpm_pkg::DEFAULT_W) : DW'(img_w_reg);
    assign dim_h = (img_h_reg == '0) ? DW'(lpm_pkg::DEFAULT_H) : DW'(img_h_reg);

    lpm_setup #(.DW(DW)) u_setup (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_wr),
        .win_w   (win_w_reg),
        .win_h   (win_h_reg),
        .img_w   (dim_w),
        .img_h   (dim_h),
        .geom    (geom)
    );

    // pipeline control
    logic en;
    logic m_tvalid_reg;
    logic va_reg, vb_reg;
    logic [DW-1:0] vc_reg;
    logic [lpm_pkg::PTR_BITS-1:0] px_reg, py_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && !geom.busy;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            va_reg       <= s_tvalid && !geom.busy;
            vb_reg       <= va_reg;
            vc_reg       <= {vc_reg[DW-2:0], vb_reg};
            m_tvalid_reg <= vc_reg[DW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= s_tdata[15:0];
            py_reg <= s_tdata[31:16];
        end
    end

    // per-axis front stage and cell row
    logic [D-1:0] res [2];

    for (genvar a = 0; a < 2; a++) begin : g_axis
        logic [lpm_pkg::PTR_BITS-1:0] p;
        logic [WB-1:0]  off, size;
        logic [DW-1:0]  dim;
        logic [16:0]    d;
        logic [14:0]    dpos;
        logic [PW-1:0]  prod;
        lpm_pkg::flags_t fl;
        logic [WB-1:0]  rem_reg;
        logic [DW-1:0]  lo_reg;
        lpm_pkg::flags_t fl_reg;
        logic [WB-1:0]  rem_c [DW+1];
        logic [DW-1:0]  lo_c  [DW+1];
        logic [DW-1:0]  q_c   [DW+1];
        lpm_pkg::flags_t fl_c [DW+1];
        logic [D-1:0]   res_reg;
        logic [DW-1:0]  fin;

        assign p    = (a == 0) ? px_reg : py_reg;
        assign off  = (a == 0) ? geom.dst_x : geom.dst_y;
        assign size = (a == 0) ? geom.dst_w : geom.dst_h;
        assign dim  = (a == 0) ? dim_w : dim_h;

        always_comb begin
            d        = {p[15], p} - {3'b000, off};
            dpos     = d[14:0];
            fl.zero  = d[16] || (size == '0);
            fl.clamp = dpos >= {1'b0, size};
            prod     = PW'(dpos) * PW'(dim);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg <= prod[DW+WB-1:DW];
                lo_reg  <= prod[DW-1:0];
                fl_reg  <= fl;
            end
        end

        assign rem_c[0] = rem_reg;
        assign lo_c[0]  = lo_reg;
        assign q_c[0]   = '0;
        assign fl_c[0]  = fl_reg;

        for (genvar k = 0; k < DW; k++) begin : g_cell
            lpm_cell #(.DW(DW)) u_cell (
                .aclk    (aclk),
                .en      (en),
                .div_i   (size),
                .rem_i   (rem_c[k]),
                .lo_i    (lo_c[k]),
                .q_i     (q_c[k]),
                .flags_i (fl_c[k]),
                .rem_o   (rem_c[k+1]),
                .lo_o    (lo_c[k+1]),
                .q_o     (q_c[k+1]),
                .flags_o (fl_c[k+1])
            );
        end

        always_comb begin
            if (fl_c[DW].zero) fin = '0;
            else if (fl_c[DW].clamp) fin = dim - 1'b1;
            else fin = q_c[DW];
        end

        always_ff @(posedge aclk) begin
            if (en) res_reg <= fin[D-1:0];
        end

        assign res[a] = res_reg;
    end

    assign m_tdata = OW'({res[1], res[0]});

    `ASSERT_IMPLY(a_busy_blocks, aclk, aresetn, geom.busy, !s_tready)
    `ASSERT_NEXT(a_cfg_recompute, aclk, aresetn, cfg_wr, geom.busy)
    `ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, va_reg)
endmodule

@@ rtl/lpm_cell.sv @@
`timescale 1ns / 1ps
module lpm_cell #(
    parameter int DW = 12
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [lpm_pkg::WIN_BITS-1:0]  div_i,
    input  logic [lpm_pkg::WIN_BITS-1:0]  rem_i,
    input  logic [DW-1:0]                 lo_i,
    input  logic [DW-1:0]                 q_i,
    input  lpm_pkg::flags_t               flags_i,
    output logic [lpm_pkg::WIN_BITS-1:0]  rem_o,
    output logic [DW-1:0]                 lo_o,
    output logic [DW-1:0]                 q_o,
    output lpm_pkg::flags_t               flags_o
);
    logic [lpm_pkg::WIN_BITS:0]   t;
    logic                         ge;
    logic [lpm_pkg::WIN_BITS-1:0] rem_next;
    logic [lpm_pkg::WIN_BITS-1:0] rem_reg;
    logic [DW-1:0]                lo_reg;
    logic [DW-1:0]                q_reg;
    lpm_pkg::flags_t              flags_reg;

    always_comb begin
        t  = {rem_i, lo_i[DW-1]};
        ge = t >= {1'b0, div_i};
        rem_next = ge ? lpm_pkg::WIN_BITS'(t - {1'b0, div_i})
                      : t[lpm_pkg::WIN_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg   <= rem_next;
            lo_reg    <= {lo_i[DW-2:0], 1'b0};
            q_reg     <= {q_i[DW-2:0], ge};
            flags_reg <= flags_i;
        end
    end

    assign rem_o   = rem_reg;
    assign lo_o    = lo_reg;
    assign q_o     = q_reg;
    assign flags_o = flags_reg;
endmodule

@@ rtl/lpm_setup.sv @@
`timescale 1ns / 1ps
module lpm_setup #(
    parameter int DW = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [lpm_pkg::WIN_BITS-1:0] win_w,
    input  logic [lpm_pkg::WIN_BITS-1:0] win_h,
    input  logic [DW-1:0]                img_w,
    input  logic [DW-1:0]                img_h,
    output lpm_pkg::geom_t               geom
);
    localparam int NB = lpm_pkg::WIN_BITS + DW;
    localparam int CW = $clog2(NB + 1);

    lpm_pkg::setup_state_t state_reg, state_next;
    logic [NB-1:0]   prod_a_reg, prod_b_reg;
    logic            fill_h_reg;
    logic [NB-1:0]   dvd_reg;
    logic [NB-1:0]   quo_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   dvs_reg;
    logic [CW-1:0]   cnt_reg;
    logic [DW:0]     t;
    logic            ge;
    logic [lpm_pkg::WIN_BITS-1:0] q14;
    logic [lpm_pkg::WIN_BITS-1:0] dst_x_reg, dst_y_reg, dst_w_reg, dst_h_reg;

    always_comb begin
        t  = {rem_reg, dvd_reg[NB-1]};
        ge = t >= {1'b0, dvs_reg};
        q14 = quo_reg[lpm_pkg::WIN_BITS-1:0];
        state_next = state_reg;
        unique case (state_reg)
            lpm_pkg::S_IDLE: state_next = lpm_pkg::S_IDLE;
            lpm_pkg::S_MUL:  state_next = lpm_pkg::S_DIV;
            lpm_pkg::S_DIV:  if (cnt_reg == CW'(NB - 1)) state_next = lpm_pkg::S_FIN;
            lpm_pkg::S_FIN:  state_next = lpm_pkg::S_IDLE;
            default:         state_next = lpm_pkg::S_IDLE;
        endcase
        if (start) state_next = lpm_pkg::S_MUL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpm_pkg::S_MUL;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            lpm_pkg::S_MUL: begin
                prod_a_reg <= NB'(win_w) * NB'(img_h);
                prod_b_reg <= NB'(win_h) * NB'(img_w);
                cnt_reg    <= '0;
            end
            lpm_pkg::S_DIV: begin
                if (cnt_reg == '0) begin
                    fill_h_reg <= prod_a_reg > prod_b_reg;
                    dvd_reg    <= (prod_a_reg > prod_b_reg) ? prod_b_reg : prod_a_reg;
                    dvs_reg    <= (prod_a_reg > prod_b_reg) ? img_h : img_w;
                    rem_reg    <= '0;
                    quo_reg    <= '0;
                    cnt_reg    <= cnt_reg + 1'b1;
                end else begin
                    dvd_reg <= {dvd_reg[NB-2:0], 1'b0};
                    rem_reg <= ge ? DW'(t - {1'b0, dvs_reg}) : t[DW-1:0];
                    quo_reg <= {quo_reg[NB-2:0], ge};
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            lpm_pkg::S_FIN: begin
                // last quotient bit still pending in this cycle
                if (fill_h_reg) begin
                    dst_h_reg <= win_h;
                    dst_w_reg <= {q14[lpm_pkg::WIN_BITS-2:0], ge};
                    dst_x_reg <= lpm_pkg::WIN_BITS'((win_w - {q14[lpm_pkg::WIN_BITS-2:0], ge})
                                 >> 1);
                    dst_y_reg <= '0;
                end else begin
                    dst_w_reg <= win_w;
                    dst_h_reg <= {q14[lpm_pkg::WIN_BITS-2:0], ge};
                    dst_x_reg <= '0;
                    dst_y_reg <= lpm_pkg::WIN_BITS'((win_h - {q14[lpm_pkg::WIN_BITS-2:0], ge})
                                 >> 1);
                end
            end
            default: ;
        endcase
    end

    assign geom.dst_x = dst_x_reg;
    assign geom.dst_y = dst_y_reg;
    assign geom.dst_w = dst_w_reg;
    assign geom.dst_h = dst_h_reg;
    assign geom.busy  = state_reg != lpm_pkg::S_IDLE;
endmodule

@@ verif/letterbox_pointer_mapper_unit_tb.sv @@
`timescale 1ns / 1ps
module letterbox_pointer_mapper_unit_tb;
    localparam int D = 12;
    localparam int OUT_W = ((2*D+7)/8)*8;
    localparam int PIPE_LAT = D + 3;
    localparam int SETUP_LAT = 16 + D;
    localparam longint CYCLE_LIMIT = 400000;

    logic             aclk;
    logic             aresetn;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [3:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    logic             s_tvalid;
    logic             s_tready;
    // [15:0] pointer_x, [31:16] pointer_y
    logic [31:0]      s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    // [11:0] image_x, [23:12] image_y
    logic [OUT_W-1:0] m_tdata;

    typedef struct packed {
        logic [D-1:0] img_y;
        logic [D-1:0] img_x;
    } pixel_t;

    logic [lpm_pkg::WIN_BITS-1:0] win_w_q;
    logic [lpm_pkg::WIN_BITS-1:0] win_h_q;
    logic [D-1:0]        img_w_q;
    logic [D-1:0]        img_h_q;

    pixel_t pixel_queue[$];
    int     mismatches = 0;
    longint cycles = 0;
    bit     hold_off;

    letterbox_pointer_mapper_unit #(.IMAGE_DIM_BITS(D)) DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("letterbox_pointer_mapper_unit verification failed");
            $finish;
        end
    end

    function automatic longint axis_pixel(longint p, longint off, longint dim, longint span);
        longint d;
        longint q;
        d = p - off;
        if (d < 0 || span == 0)
            return 0;
        q = (d * dim) / span;
        if (q >= dim)
            q = dim - 1;
        return q;
    endfunction

    function automatic pixel_t map_pointer(logic [15:0] px, logic [15:0] py);
        longint iw, ih, ww, wh, dx, dy, dw, dh;
        pixel_t r;
        iw = (img_w_q == 0) ? lpm_pkg::DEFAULT_W : img_w_q;
        ih = (img_h_q == 0) ? lpm_pkg::DEFAULT_H : img_h_q;
        ww = win_w_q;
        wh = win_h_q;
        if (ww * ih > wh * iw) begin
            dh = wh;
            dw = (wh * iw) / ih;
            dx = (ww - dw) / 2;
            dy = 0;
        end else begin
            dw = ww;
            dh = (ww * ih) / iw;
            dx = 0;
            dy = (wh - dh) / 2;
        end
        r.img_x = D'(axis_pixel(longint'($signed(px)), dx, iw, dw));
        r.img_y = D'(axis_pixel(longint'($signed(py)), dy, ih, dh));
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[2*D-1:0];
            if (pixel_queue.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected word %h", got);
            end else begin
                want = pixel_queue.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: x exp %0d got %0d, y exp %0d got %0d",
                                 want.img_x, got.img_x, want.img_y, got.img_y);
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!aresetn)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else if (r < 70)
            m_tready <= 1'b1;
        else if (r < 97)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 7) == 0);
    end

    task automatic wait_cycles(int n);
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        while (pixel_queue.size() != 0)
            @(posedge aclk);
        wait_cycles(PIPE_LAT + 4);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        case (idx)
            lpm_pkg::REG_WIN_W: win_w_q = value[lpm_pkg::WIN_BITS-1:0];
            lpm_pkg::REG_WIN_H: win_h_q = value[lpm_pkg::WIN_BITS-1:0];
            lpm_pkg::REG_IMG_W: img_w_q = value[D-1:0];
            lpm_pkg::REG_IMG_H: img_h_q = value[D-1:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_geometry(int ww, int wh, int iw, int ih);
        drain();
        write_reg(lpm_pkg::REG_WIN_W, ww);
        write_reg(lpm_pkg::REG_WIN_H, wh);
        write_reg(lpm_pkg::REG_IMG_W, iw);
        write_reg(lpm_pkg::REG_IMG_H, ih);
    endtask

    task automatic send_pointer(logic [15:0] px, logic [15:0] py, bit gaps);
        int g;
        if (gaps) begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
            if (g != 0) begin
                s_tvalid <= 1'b0;
                wait_cycles(g);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pixel_queue.push_back(map_pointer(px, py));
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coord(int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'($urandom);
        else if (r == 1)
            return 16'(-$urandom_range(1, 50));
        else
            return 16'($urandom_range(0, span + 20));
    endfunction

    task automatic test_directed_edges();
        logic [15:0] pts[10];
        pts = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'd1,
                16'd319, 16'd320, 16'd639, 16'd640, 16'h5555};
        for (int i = 0; i < 10; i++)
            send_pointer(pts[i], pts[9 - i], 1'b0);
        send_pointer(16'haaaa, 16'd479, 1'b0);
        send_pointer(16'd80, 16'd480, 1'b0);
        end_burst();
    endtask

    task automatic test_pillarbox();
        set_geometry(1000, 300, 0, 0);
        for (int i = 0; i < 8; i++)
            send_pointer(16'(i * 140), 16'(i * 45), 1'b0);
        end_burst();
    endtask

    task automatic test_letterbox_extremes();
        set_geometry(16383, 1, 4095, 4095);
        send_pointer(16'd8191, 16'd0, 1'b0);
        send_pointer(16'd8192, 16'd1, 1'b0);
        end_burst();
        set_geometry(1, 16383, 1, 1);
        send_pointer(16'd0, 16'd8191, 1'b0);
        send_pointer(16'hffff, 16'h7fff, 1'b0);
        end_burst();
        // window dimension zero through masked high bits
        set_geometry(32'hffff_c000, 200, 32'hffff_f000, 0);
        send_pointer(16'd5, 16'd100, 1'b0);
        send_pointer(16'h7fff, 16'd199, 1'b0);
        end_burst();
    endtask

    task automatic test_random_geometry(int phases, int per_phase);
        int ww, wh;
        for (int p = 0; p < phases; p++) begin
            ww = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16383) : $urandom_range(1, 2000);
            wh = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16383) : $urandom_range(1, 2000);
            set_geometry(ww | ($urandom & 32'hffff_c000), wh,
                         ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4095),
                         ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4095));
            for (int i = 0; i < per_phase; i++)
                send_pointer(rand_coord(ww), rand_coord(wh), (p % 3) != 0);
            end_burst();
        end
    endtask

    task automatic test_back_pressure();
        drain();
        hold_off = 1'b1;
        fork
            begin
                wait_cycles(400);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 80; i++)
                send_pointer(16'($urandom), 16'($urandom), 1'b0);
        join
        end_burst();
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        hold_off = 1'b0;
        win_w_q = 640;
        win_h_q = 480;
        img_w_q = 0;
        img_h_q = 0;
        wait_cycles(6);
        aresetn <= 1'b1;
        test_directed_edges();
        test_pillarbox();
        test_letterbox_extremes();
        test_back_pressure();
        test_random_geometry(26, 48);
        drain();
        wait_cycles(SETUP_LAT);
        if (mismatches == 0 && pixel_queue.size() == 0)
            $display("letterbox_pointer_mapper_unit verification clean");
        else
            $display("letterbox_pointer_mapper_unit verification failed");
        $finish;
    end
endmodule
